/* hdl/dmu_pkg.sv */
// Shared types, constants and reset values of the PPS to UTC delay meter.
package dmu_pkg;

    localparam int COUNT_WIDTH_DEFAULT = 32;

    localparam int LEVEL_W  = 12;
    localparam int MS_W     = 30;
    localparam int TENTHS_W = 23;
    localparam int SEC_W    = 20;
    localparam int DIGIT_W  = 4;
    localparam int SPT_W    = 17;
    localparam int MAXD_W   = 16;
    localparam int SUB_W    = SPT_W + DIGIT_W;
    localparam int DELAY_W  = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PPS_THRESHOLD     = 2'd0,
        CFG_SAMPLES_PER_TENTH = 2'd1,
        CFG_DELAY_LIMIT       = 2'd2,
        CFG_UNUSED            = 2'd3
    } cfg_index_t;

    localparam logic [LEVEL_W-1:0] THR_RESET  = 12'd2048;
    localparam logic [SPT_W-1:0]   SPT_RESET  = 17'd50;
    localparam logic [MAXD_W-1:0]  MAXD_RESET = 16'd30;

    localparam logic signed [DELAY_W-1:0] HELD_RESET     = 32'sd16;
    localparam logic signed [DELAY_W-1:0] DELAY_NO_PULSE = -32'sd1;
    localparam logic signed [DELAY_W-1:0] DELAY_TOO_LATE = -32'sd2;

    // Half of one tenth in milliseconds, for round half up.
    localparam logic [MS_W:0] ROUND_MS = 31'd50;

    // floor(x / 100) = (x * DIV100_MAGIC) >> DIV100_SHIFT for x below 2^31.
    localparam logic [31:0] DIV100_MAGIC = 32'd2748779070;
    localparam int          DIV100_SHIFT = 38;
    // floor(x / 10) = (x * DIV10_MAGIC) >> DIV10_SHIFT for x below 2^23.
    localparam logic [23:0] DIV10_MAGIC  = 24'd6710887;
    localparam int          DIV10_SHIFT  = 26;

    localparam logic [TENTHS_W-1:0] TENTHS_MAX = 23'd8388607;

    typedef struct packed {
        logic [LEVEL_W-1:0]  level;
        logic [TENTHS_W-1:0] tenths;
        logic [SEC_W-1:0]    seconds;
        logic [SUB_W-1:0]    sub;
    } dmu_item_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] pps_threshold;
        logic [MAXD_W-1:0]  delay_limit;
    } dmu_core_cfg_t;

endpackage

/* hdl/dmu_front.sv */
// Input register and time arithmetic pipeline: UTC tenths, seconds, digit and fraction term.
module dmu_front
    import dmu_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [LEVEL_W-1:0]  pps_level,
    input  logic [MS_W-1:0]     utc_ms,
    input  logic [SPT_W-1:0]    samples_per_tenth,
    output logic                item_valid,
    input  logic                item_take,
    output dmu_item_t           item
);

    logic v0_reg, v1_reg, v2_reg, v3_reg;
    logic ready0, ready1, ready2, ready3;

    logic [LEVEL_W-1:0]  lvl0_reg, lvl1_reg, lvl2_reg;
    logic [MS_W-1:0]     ms0_reg;
    logic [TENTHS_W-1:0] t1_reg, t2_reg;
    logic [SEC_W-1:0]    sec2_reg;
    logic [DIGIT_W-1:0]  dig2_reg;
    dmu_item_t           item_reg;

    logic [MS_W:0]       ms_round;
    logic [62:0]         prod100;
    logic [24:0]         quot100;
    logic [TENTHS_W-1:0] t1_next;
    logic [46:0]         prod10;
    logic [SEC_W-1:0]    sec2_next;
    logic [TENTHS_W-1:0] sec_times10;
    logic [DIGIT_W-1:0]  dig2_next;
    logic [SUB_W-1:0]    sub_next;

    assign ready3 = !v3_reg || item_take;
    assign ready2 = !v2_reg || ready3;
    assign ready1 = !v1_reg || ready2;
    assign ready0 = !v0_reg || ready1;
    assign in_stall = !ready0;

    always_comb
    begin
        ms_round    = {1'b0, ms0_reg} + ROUND_MS;
        prod100     = 63'({31'd0, ms_round}) * 63'(DIV100_MAGIC);
        quot100     = prod100[DIV100_SHIFT+24:DIV100_SHIFT];
        t1_next     = (quot100 > 25'(TENTHS_MAX)) ? TENTHS_MAX : quot100[TENTHS_W-1:0];

        prod10      = 47'(t1_reg) * 47'(DIV10_MAGIC);
        sec2_next   = prod10[DIV10_SHIFT+SEC_W-1:DIV10_SHIFT];
        sec_times10 = TENTHS_W'({sec2_next, 3'b000}) + TENTHS_W'({sec2_next, 1'b0});
        dig2_next   = DIGIT_W'(t1_reg - sec_times10);

        sub_next    = SUB_W'(dig2_reg) * SUB_W'(samples_per_tenth);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (ready0)
            begin
                v0_reg <= in_valid;
            end
            if (ready1)
            begin
                v1_reg <= v0_reg;
            end
            if (ready2)
            begin
                v2_reg <= v1_reg;
            end
            if (ready3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready0 && in_valid)
        begin
            lvl0_reg <= pps_level;
            ms0_reg  <= utc_ms;
        end
        if (ready1 && v0_reg)
        begin
            lvl1_reg <= lvl0_reg;
            t1_reg   <= t1_next;
        end
        if (ready2 && v1_reg)
        begin
            lvl2_reg <= lvl1_reg;
            t2_reg   <= t1_reg;
            sec2_reg <= sec2_next;
            dig2_reg <= dig2_next;
        end
        if (ready3 && v2_reg)
        begin
            item_reg.level   <= lvl2_reg;
            item_reg.tenths  <= t2_reg;
            item_reg.seconds <= sec2_reg;
            item_reg.sub     <= sub_next;
        end
    end

    assign item_valid = v3_reg;
    assign item       = item_reg;

endmodule

/* hdl/dmu_core.sv */
// Sample counter, edge stamping, second latch and delay computation with the result register.
module dmu_core
    import dmu_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    output logic                       item_take,
    input  dmu_item_t                  item,
    input  dmu_core_cfg_t              cfg,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [DELAY_W-1:0]  delay_samples
);

    localparam int EW = (COUNT_WIDTH > 34) ? COUNT_WIDTH : 34;
    localparam logic [EW-1:0]        ELAPSED_CAP = EW'(64'h2_0000_0000);
    localparam logic signed [34:0]   SAT_HIGH = 35'sd2147483647;
    localparam logic signed [34:0]   SAT_LOW  = -35'sd2147483648;

    logic [COUNT_WIDTH-1:0] sample_count_reg, sample_count_next;
    logic                   start_high_hold_reg, start_high_hold_next;
    logic                   pulse_high_reg, pulse_high_next;
    logic [COUNT_WIDTH-1:0] edge_stamp_reg, edge_stamp_next;
    logic                   edge_stamp_valid_reg, edge_stamp_valid_next;
    logic [COUNT_WIDTH-1:0] second_stamp_reg, second_stamp_next;
    logic                   second_stamp_valid_reg, second_stamp_valid_next;
    logic [TENTHS_W-1:0]    last_tenths_reg, last_tenths_next;
    logic [SEC_W-1:0]       last_sec_reg, last_sec_next;
    logic signed [DELAY_W-1:0] held_delay_reg, held_delay_next;
    logic                   out_valid_reg;

    logic                   fire;
    logic                   first;
    logic                   level_high;
    logic [TENTHS_W-1:0]    last_tenths_eff;
    logic [SEC_W-1:0]       last_sec_eff;
    logic                   changed;
    logic [COUNT_WIDTH-1:0] elapsed;
    logic [EW-1:0]          elapsed_ext;
    logic [33:0]            elapsed_clamp;
    logic signed [34:0]     diff;
    logic signed [DELAY_W-1:0] delay_sat;
    logic signed [DELAY_W-1:0] held_flagged;

    assign item_take = !out_valid_reg || !out_stall;
    assign fire      = item_valid && item_take;

    always_comb
    begin
        first      = (sample_count_reg == '0);
        level_high = (item.level >= cfg.pps_threshold);

        start_high_hold_next  = start_high_hold_reg;
        pulse_high_next       = pulse_high_reg;
        edge_stamp_next       = edge_stamp_reg;
        edge_stamp_valid_next = edge_stamp_valid_reg;
        if (level_high)
        begin
            if (first)
            begin
                start_high_hold_next = 1'b1;
            end
            else if (!pulse_high_reg && !start_high_hold_reg)
            begin
                pulse_high_next       = 1'b1;
                edge_stamp_next       = sample_count_reg;
                edge_stamp_valid_next = 1'b1;
            end
        end
        else
        begin
            pulse_high_next      = 1'b0;
            start_high_hold_next = 1'b0;
        end

        last_tenths_eff = first ? item.tenths : last_tenths_reg;
        last_sec_eff    = first ? item.seconds : last_sec_reg;
        changed         = (item.tenths != last_tenths_eff);

        second_stamp_next       = second_stamp_reg;
        second_stamp_valid_next = second_stamp_valid_reg;
        if (changed && (item.seconds > last_sec_eff))
        begin
            second_stamp_next       = edge_stamp_next;
            second_stamp_valid_next = edge_stamp_valid_next;
        end

        elapsed       = sample_count_reg - second_stamp_next;
        elapsed_ext   = EW'(elapsed);
        elapsed_clamp = (elapsed_ext > ELAPSED_CAP) ? ELAPSED_CAP[33:0] : elapsed_ext[33:0];
        diff          = $signed({1'b0, elapsed_clamp}) - $signed(35'(item.sub));
        if (diff > SAT_HIGH)
        begin
            delay_sat = SAT_HIGH[DELAY_W-1:0];
        end
        else if (diff < SAT_LOW)
        begin
            delay_sat = SAT_LOW[DELAY_W-1:0];
        end
        else
        begin
            delay_sat = diff[DELAY_W-1:0];
        end

        held_flagged = changed ? delay_sat : held_delay_reg;
        if (!second_stamp_valid_next)
        begin
            held_flagged = DELAY_NO_PULSE;
        end
        if ($signed({held_flagged[DELAY_W-1], held_flagged}) >
            $signed({17'd0, cfg.delay_limit}))
        begin
            held_flagged = DELAY_TOO_LATE;
        end
        held_delay_next = held_flagged;

        last_tenths_next  = (first || changed) ? item.tenths : last_tenths_reg;
        last_sec_next     = (first || changed) ? item.seconds : last_sec_reg;
        sample_count_next = sample_count_reg + COUNT_WIDTH'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_count_reg       <= '0;
            start_high_hold_reg    <= 1'b0;
            pulse_high_reg         <= 1'b0;
            edge_stamp_reg         <= '0;
            edge_stamp_valid_reg   <= 1'b0;
            second_stamp_reg       <= '0;
            second_stamp_valid_reg <= 1'b0;
            last_tenths_reg        <= '0;
            last_sec_reg           <= '0;
            held_delay_reg         <= HELD_RESET;
            out_valid_reg          <= 1'b0;
        end
        else
        begin
            if (item_take)
            begin
                out_valid_reg <= item_valid;
            end
            if (fire)
            begin
                sample_count_reg       <= sample_count_next;
                start_high_hold_reg    <= start_high_hold_next;
                pulse_high_reg         <= pulse_high_next;
                edge_stamp_reg         <= edge_stamp_next;
                edge_stamp_valid_reg   <= edge_stamp_valid_next;
                second_stamp_reg       <= second_stamp_next;
                second_stamp_valid_reg <= second_stamp_valid_next;
                last_tenths_reg        <= last_tenths_next;
                last_sec_reg           <= last_sec_next;
                held_delay_reg         <= held_delay_next;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign delay_samples = held_delay_reg;

    // Without a latched stamp the result shown must be the no-pulse flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !second_stamp_valid_reg) |-> (held_delay_reg == DELAY_NO_PULSE))
        else $error("result without latched stamp is not the no-pulse flag");

    // A latched stamp can only come from a seen edge.
    assert property (@(posedge clk) disable iff (!rst_n)
        second_stamp_valid_reg |-> edge_stamp_valid_reg)
        else $error("second stamp valid without edge stamp");

    // Once an edge has been stamped, the stamp stays valid.
    assert property (@(posedge clk) disable iff (!rst_n)
        edge_stamp_valid_reg |=> edge_stamp_valid_reg)
        else $error("edge stamp valid dropped");

endmodule

/* hdl/pps_to_utc_delay_meter_unit.sv */
// Top level of the PPS to UTC delay meter: configuration registers and pipeline assembly.
//
// One input transfer is one sample tick carrying the PPS level and the UTC time in
// milliseconds; each one yields exactly one output transfer with the delay in samples,
// -1 while no pulse stamp is latched and -2 when the delay exceeds the delay limit.
// A transfer happens on a rising edge of clk with valid high and stall low.
// Throughput is one item per cycle while out_stall is low, set by the single state
// update stage after the four-stage arithmetic pipeline (input register, rounding
// divide by 100, divide by 10, fraction multiply).
// When the receiver stalls, the result register holds and the pipeline keeps filling
// its empty stages; in_stall rises only when all four arithmetic stages and the result
// register are full while out_stall is high, and it falls in the cycle out_stall falls.
// Configuration writes use cfg_valid/cfg_ready with cfg_index 0 (pps_threshold),
// 1 (samples_per_tenth) and 2 (delay limit); cfg_ready is always high and other indexes
// are ignored. Write configuration only while no item is in flight.
// Reset (rst_n low) empties the pipeline, clears the sample counter and stamps, sets
// the held delay to 16 and restores the configuration defaults.
module pps_to_utc_delay_meter_unit
    import dmu_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [LEVEL_W-1:0]         pps_level,
    input  logic [MS_W-1:0]            utc_ms,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [DELAY_W-1:0]  delay_samples,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data
);

    logic [LEVEL_W-1:0] pps_threshold_reg;
    logic [SPT_W-1:0]   samples_per_tenth_reg;
    logic [MAXD_W-1:0]  delay_limit_reg;

    logic               item_valid;
    logic               item_take;
    dmu_item_t          item;
    dmu_core_cfg_t      core_cfg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pps_threshold_reg     <= THR_RESET;
            samples_per_tenth_reg <= SPT_RESET;
            delay_limit_reg       <= MAXD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_PPS_THRESHOLD:     pps_threshold_reg     <= cfg_data[LEVEL_W-1:0];
                CFG_SAMPLES_PER_TENTH: samples_per_tenth_reg <= cfg_data[SPT_W-1:0];
                CFG_DELAY_LIMIT:       delay_limit_reg       <= cfg_data[MAXD_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign core_cfg.pps_threshold = pps_threshold_reg;
    assign core_cfg.delay_limit   = delay_limit_reg;

    dmu_front u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .pps_level         (pps_level),
        .utc_ms            (utc_ms),
        .samples_per_tenth (samples_per_tenth_reg),
        .item_valid        (item_valid),
        .item_take         (item_take),
        .item              (item)
    );

    dmu_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_take     (item_take),
        .item          (item),
        .cfg           (core_cfg),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .delay_samples (delay_samples)
    );

endmodule
